@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property on every clock edge outside reset.
`define WFTS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define WFTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define WFTS_ASSERT(lbl, clk, rstn, prop, msg)
`define WFTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

@@ hw/rtl/wfts_pkg.sv @@
package wfts_pkg;

    localparam int TASK_ID_W     = 22;
    localparam int NICE_W        = 3;
    localparam int RT_W          = 48;
    localparam int WEIGHT_W      = 17;
    localparam int NUM_WEIGHTS   = 5;
    localparam int CFG_IDX_W     = 3;
    localparam int S_DATA_W      = 32;
    localparam int M_USER_W      = 2;
    localparam int DEF_MAX_TASKS = 16;

    typedef logic [CFG_IDX_W-1:0] widx_t;

    localparam widx_t WIDX_MINUS2 = 3'd0;
    localparam widx_t WIDX_MINUS1 = 3'd1;
    localparam widx_t WIDX_ZERO   = 3'd2;
    localparam widx_t WIDX_PLUS1  = 3'd3;
    localparam widx_t WIDX_PLUS2  = 3'd4;

    localparam logic [NICE_W-1:0] NICE_MINUS1 = 3'b111;
    localparam logic [NICE_W-1:0] NICE_ZERO   = 3'b000;
    localparam logic [NICE_W-1:0] NICE_PLUS1  = 3'b001;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef logic [WEIGHT_W-1:0] weight_t;

    localparam weight_t WEIGHT_RESET [NUM_WEIGHTS] = '{
        17'd41943, 17'd52429, 17'd65536, 17'd81920, 17'd102400
    };

    typedef struct packed {
        logic [RT_W-1:0]      rt;
        logic [NICE_W-1:0]    nice;
        logic [TASK_ID_W-1:0] id;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD,
        ST_WALK,
        ST_EMIT
    } st_t;

    // Saturate out-of-range nice codes to the nearest weight.
    function automatic widx_t weight_index(input logic [NICE_W-1:0] nice);
        widx_t idx;
        if (nice[NICE_W-1]) begin
            idx = (nice == NICE_MINUS1) ? WIDX_MINUS1 : WIDX_MINUS2;
        end else if (nice == NICE_ZERO) begin
            idx = WIDX_ZERO;
        end else if (nice == NICE_PLUS1) begin
            idx = WIDX_PLUS1;
        end else begin
            idx = WIDX_PLUS2;
        end
        return idx;
    endfunction

endpackage

@@ hw/rtl/weighted_fair_task_scheduler.sv @@
// Channel | Direction | Handshake          | Payload
// s_      | in        | s_tvalid/s_tready  | tuser: kind; tdata: task_id, nice_level
// m_      | out       | m_tvalid/m_tready  | tuser: running_valid, add_rejected;
//         |           |                    | tdata: running_id, running_nice,
//         |           |                    |        running_vruntime, queue_count
// cfg_    | in        | cfg_valid/cfg_ready| cfg_addr: weight index; cfg_wdata: weight
//
// An add goes from ST_IDLE straight to ST_EMIT; a tick on a non-empty queue passes ST_HEAD
// and may walk the queue RAM in ST_WALK, one entry a cycle on its one read and one write port.
// Reset (aresetn low, synchronous) empties the queue and clears the running task.
// s_tready is high only between items; a held result keeps the block in ST_EMIT,
// so the next input transfer waits until the output register frees.
// Configuration writes are always taken.
`include "assert_macros.svh"

module weighted_fair_task_scheduler #(
    parameter int MAX_TASKS = wfts_pkg::DEF_MAX_TASKS,
    localparam int CNT_W    = $clog2(MAX_TASKS + 1),
    localparam int OUT_BITS = wfts_pkg::TASK_ID_W + wfts_pkg::NICE_W + wfts_pkg::RT_W + CNT_W,
    localparam int M_DATA_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [wfts_pkg::S_DATA_W-1:0]     s_tdata,   // task_id, nice_level
    input  logic                              s_tuser,   // kind

    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [M_DATA_W-1:0]               m_tdata,   // running_id, running_nice,
                                                         // running_vruntime, queue_count
    output logic [wfts_pkg::M_USER_W-1:0]     m_tuser,   // running_valid, add_rejected

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wfts_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [wfts_pkg::WEIGHT_W-1:0]     cfg_wdata
);

    import wfts_pkg::*;

    localparam int IDX_W = $clog2(MAX_TASKS);

    st_t state_reg, state_next;

    weight_t weight_reg [NUM_WEIGHTS];

    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     j_reg, j_next;
    logic                 pop_reg, pop_next;
    logic                 rej_reg, rej_next;
    logic                 cur_valid_reg, cur_valid_next;
    logic [TASK_ID_W-1:0] cur_id_reg, cur_id_next;
    logic [NICE_W-1:0]    cur_nice_reg, cur_nice_next;
    logic [RT_W-1:0]      cur_rt_reg, cur_rt_next;
    logic [TASK_ID_W-1:0] ins_id_reg, ins_id_next;
    logic [NICE_W-1:0]    ins_nice_reg, ins_nice_next;
    logic [RT_W-1:0]      ins_rt_reg, ins_rt_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [M_USER_W-1:0]  m_tuser_reg, m_tuser_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    entry_t               ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    entry_t               rd_entry;

    logic                 s_fire;
    logic                 out_free;
    logic                 at_end;
    logic                 rt_le;
    logic                 q_full;
    logic [CNT_W-1:0]     j_dec;
    logic [CNT_W-1:0]     j_inc;
    logic [RT_W:0]        charge_sum;
    logic [RT_W-1:0]      charged_rt;
    weight_t              cur_weight;
    logic [OUT_BITS-1:0]  out_fields;

    wfts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_queue_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry  = entry_t'(ram_rdata);
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign at_end    = (j_reg == cnt_reg);
    assign rt_le     = (ins_rt_reg <= rd_entry.rt);
    assign q_full    = (cnt_reg == CNT_W'(MAX_TASKS));
    assign j_dec     = j_reg - CNT_W'(1);
    assign j_inc     = j_reg + CNT_W'(1);
    assign cfg_ready = 1'b1;

    assign cur_weight = weight_reg[weight_index(cur_nice_reg)];
    assign charge_sum = {1'b0, cur_rt_reg} + (RT_W + 1)'(cur_weight);
    assign charged_rt = charge_sum[RT_W] ? {RT_W{1'b1}} : charge_sum[RT_W-1:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_tuser == KIND_ADD || cnt_reg == '0) begin
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_HEAD;
                    end
                end
            end
            ST_HEAD: begin
                if (!pop_reg && rt_le) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (at_end || (!pop_reg && rt_le)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cnt_next       = cnt_reg;
        j_next         = j_reg;
        pop_next       = pop_reg;
        rej_next       = rej_reg;
        cur_valid_next = cur_valid_reg;
        cur_id_next    = cur_id_reg;
        cur_nice_next  = cur_nice_reg;
        cur_rt_next    = cur_rt_reg;
        ins_id_next    = ins_id_reg;
        ins_nice_next  = ins_nice_reg;
        ins_rt_next    = ins_rt_reg;
        ram_we         = 1'b0;
        ram_waddr      = j_dec[IDX_W-1:0];
        ram_wdata      = rd_entry;
        ram_raddr      = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_tuser == KIND_ADD) begin
                        rej_next = q_full;
                        if (!q_full) begin
                            ram_we         = 1'b1;
                            ram_waddr      = cnt_reg[IDX_W-1:0];
                            ram_wdata.rt   = '0;
                            ram_wdata.nice = s_tdata[TASK_ID_W +: NICE_W];
                            ram_wdata.id   = s_tdata[TASK_ID_W-1:0];
                            cnt_next       = cnt_reg + CNT_W'(1);
                        end
                    end else begin
                        rej_next = 1'b0;
                        pop_next = !cur_valid_reg;
                        if (cur_valid_reg) begin
                            cur_rt_next = charged_rt;
                            ins_rt_next = charged_rt;
                        end
                    end
                end
            end
            ST_HEAD: begin
                ram_raddr = IDX_W'(1);
                j_next    = CNT_W'(1);
                if (pop_reg || !rt_le) begin
                    cur_valid_next = 1'b1;
                    cur_id_next    = rd_entry.id;
                    cur_nice_next  = rd_entry.nice;
                    cur_rt_next    = rd_entry.rt;
                    ins_id_next    = cur_id_reg;
                    ins_nice_next  = cur_nice_reg;
                end
            end
            ST_WALK: begin
                ram_raddr = j_inc[IDX_W-1:0];
                if (pop_reg) begin
                    if (at_end) begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end else begin
                        ram_we = 1'b1;
                        j_next = j_inc;
                    end
                end else if (at_end || rt_le) begin
                    ram_we         = 1'b1;
                    ram_wdata.rt   = ins_rt_reg;
                    ram_wdata.nice = ins_nice_reg;
                    ram_wdata.id   = ins_id_reg;
                end else begin
                    ram_we = 1'b1;
                    j_next = j_inc;
                end
            end
            ST_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    assign out_fields = {
        cnt_reg,
        cur_valid_reg ? cur_rt_reg   : {RT_W{1'b0}},
        cur_valid_reg ? cur_nice_reg : {NICE_W{1'b0}},
        cur_valid_reg ? cur_id_reg   : {TASK_ID_W{1'b0}}
    };

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (state_reg == ST_EMIT && out_free) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_DATA_W'(out_fields);
            m_tuser_next  = {rej_reg, cur_valid_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            j_reg         <= '0;
            pop_reg       <= 1'b0;
            rej_reg       <= 1'b0;
            cur_valid_reg <= 1'b0;
            cur_id_reg    <= '0;
            cur_nice_reg  <= '0;
            cur_rt_reg    <= '0;
            m_tvalid_reg  <= 1'b0;
            for (int i = 0; i < NUM_WEIGHTS; i++) begin
                weight_reg[i] <= WEIGHT_RESET[i];
            end
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            j_reg         <= j_next;
            pop_reg       <= pop_next;
            rej_reg       <= rej_next;
            cur_valid_reg <= cur_valid_next;
            cur_id_reg    <= cur_id_next;
            cur_nice_reg  <= cur_nice_next;
            cur_rt_reg    <= cur_rt_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_valid && cfg_ready && cfg_addr < CFG_IDX_W'(NUM_WEIGHTS)) begin
                weight_reg[cfg_addr] <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ins_id_reg   <= ins_id_next;
        ins_nice_reg <= ins_nice_next;
        ins_rt_reg   <= ins_rt_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `WFTS_ASSERT(a_cnt_bound, aclk, aresetn, cnt_reg <= CNT_W'(MAX_TASKS), "queue count overflow")
    `WFTS_ASSERT(a_walk_range, aclk, aresetn, (state_reg == ST_WALK) |-> (j_reg != '0 && j_reg <= cnt_reg), "walk index out of range")
    `WFTS_ASSERT_NEXT(a_add_count, aclk, aresetn, s_fire && s_tuser == KIND_ADD && !q_full, cnt_reg == $past(cnt_reg) + CNT_W'(1), "add did not grow queue")
    `WFTS_ASSERT_NEXT(a_tick_keep, aclk, aresetn, s_fire && s_tuser == KIND_TICK && cur_valid_reg, cur_valid_reg && cnt_reg == $past(cnt_reg), "tick changed queue count")

endmodule

@@ hw/rtl/wfts_ram.sv @@
module wfts_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
